### rtl/grid_neighbour_frontier_expander_unit_defines.svh
// assertion macros for the grid neighbour frontier expander
// used by the top level, expects clock and reset in scope
`ifndef GRID_NEIGHBOUR_FRONTIER_EXPANDER_UNIT_DEFINES_SVH
`define GRID_NEIGHBOUR_FRONTIER_EXPANDER_UNIT_DEFINES_SVH

// same-cycle implication
`define GNFE_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define GNFE_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/gnfe_pkg.sv
// shared types, constants and the neighbour offset table
// used by gnfe_csr and grid_neighbour_frontier_expander_unit
package gnfe_pkg;

   localparam int DEF_ROWS = 16;
   localparam int DEF_COLS = 16;

   localparam int CELL_W     = 5;
   localparam int COUNT_W    = 9;
   localparam int COORD_W    = 8;
   localparam int OFF_W      = 3;
   localparam int RING_IDX_W = 5;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [RING_IDX_W-1:0] RING1_FIRST = 5'd0;
   localparam logic [RING_IDX_W-1:0] RING1_LAST  = 5'd7;
   localparam logic [RING_IDX_W-1:0] RING2_FIRST = 5'd8;
   localparam logic [RING_IDX_W-1:0] RING2_LAST  = 5'd23;

   localparam logic [COUNT_W-1:0] COUNT_MAX = 9'd511;

   localparam logic [1:0] RING_LEVEL_ONE = 2'd1;
   localparam logic [1:0] RING_LEVEL_TWO = 2'd2;

   localparam logic REG_RING_LEVEL = 1'b0;
   localparam logic REG_KEEP_MARKS = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CALC,
      ST_TEST,
      ST_EMIT,
      ST_END,
      ST_END_WAIT,
      ST_SWEEP_RD,
      ST_SWEEP_WR
   } state_type;

   typedef struct packed {
      logic [1:0] ring_level;
      logic       keep_marks;
   } cfg_type;

   typedef struct packed {
      logic signed [OFF_W-1:0] dr;
      logic signed [OFF_W-1:0] dc;
   } offset_type;

   function automatic offset_type ring_offset(input logic [RING_IDX_W-1:0] idx);
      offset_type o;
      case (idx)
         5'd0:    o = '{dr: -3'sd1, dc: -3'sd1};
         5'd1:    o = '{dr: -3'sd1, dc:  3'sd0};
         5'd2:    o = '{dr: -3'sd1, dc:  3'sd1};
         5'd3:    o = '{dr:  3'sd0, dc: -3'sd1};
         5'd4:    o = '{dr:  3'sd0, dc:  3'sd1};
         5'd5:    o = '{dr:  3'sd1, dc: -3'sd1};
         5'd6:    o = '{dr:  3'sd1, dc:  3'sd0};
         5'd7:    o = '{dr:  3'sd1, dc:  3'sd1};
         5'd8:    o = '{dr: -3'sd2, dc: -3'sd2};
         5'd9:    o = '{dr: -3'sd2, dc: -3'sd1};
         5'd10:   o = '{dr: -3'sd2, dc:  3'sd0};
         5'd11:   o = '{dr: -3'sd2, dc:  3'sd1};
         5'd12:   o = '{dr: -3'sd2, dc:  3'sd2};
         5'd13:   o = '{dr: -3'sd1, dc: -3'sd2};
         5'd14:   o = '{dr: -3'sd1, dc:  3'sd2};
         5'd15:   o = '{dr:  3'sd0, dc: -3'sd2};
         5'd16:   o = '{dr:  3'sd0, dc:  3'sd2};
         5'd17:   o = '{dr:  3'sd1, dc: -3'sd2};
         5'd18:   o = '{dr:  3'sd1, dc:  3'sd2};
         5'd19:   o = '{dr:  3'sd2, dc: -3'sd2};
         5'd20:   o = '{dr:  3'sd2, dc: -3'sd1};
         5'd21:   o = '{dr:  3'sd2, dc:  3'sd0};
         5'd22:   o = '{dr:  3'sd2, dc:  3'sd1};
         5'd23:   o = '{dr:  3'sd2, dc:  3'sd2};
         default: o = '{dr:  3'sd0, dc:  3'sd0};
      endcase
      return o;
   endfunction

endpackage

### rtl/gnfe_csr.sv
// configuration registers behind the apb-style port
// depends on gnfe_pkg
module gnfe_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [gnfe_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [gnfe_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [gnfe_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready,
   output gnfe_pkg::cfg_type                cfg
);
   import gnfe_pkg::*;

   logic [1:0] ring_level_ff, ring_level_in;
   logic       keep_marks_ff, keep_marks_in;
   logic       wr_xfer;
   logic       reg_sel;

   assign csr_pready = 1'b1;
   assign reg_sel    = csr_paddr[2];
   assign wr_xfer    = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      ring_level_in = ring_level_ff;
      keep_marks_in = keep_marks_ff;
      if (wr_xfer) begin
         case (reg_sel)
            REG_RING_LEVEL: ring_level_in = csr_pwdata[1:0];
            REG_KEEP_MARKS: keep_marks_in = csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ring_level_ff <= RING_LEVEL_ONE;
         keep_marks_ff <= 1'b1;
      end else begin
         ring_level_ff <= ring_level_in;
         keep_marks_ff <= keep_marks_in;
      end
   end

   always_comb begin
      case (reg_sel)
         REG_RING_LEVEL: csr_prdata = {{(CSR_DATA_W-2){1'b0}}, ring_level_ff};
         REG_KEEP_MARKS: csr_prdata = {{(CSR_DATA_W-1){1'b0}}, keep_marks_ff};
         default:        csr_prdata = '0;
      endcase
   end

   assign cfg.ring_level = ring_level_ff;
   assign cfg.keep_marks = keep_marks_ff;

endmodule

### rtl/grid_neighbour_frontier_expander_unit.sv
// a clear item goes straight to its end transfer after acceptance. an expand item steps
// through its ring offsets on the one coordinate adder: an off-board offset takes an address
// step, a visited one an address step and a check, a new one both plus its output transfer,
// which can stall; the end transfer follows. a last cell with keep_marks 0 adds a revert
// sweep over every row. throughput: one item at a time. reset: synchronous, clears the
// sequencer, valid bits and list count; config resets to ring 1 with marks kept
module grid_neighbour_frontier_expander_unit #(
   parameter int ROWS = gnfe_pkg::DEF_ROWS,
   parameter int COLS = gnfe_pkg::DEF_COLS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_mode,
   input  logic [gnfe_pkg::CELL_W-1:0]      req_cell_row,
   input  logic [gnfe_pkg::CELL_W-1:0]      req_cell_col,
   input  logic                             req_last_cell,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [gnfe_pkg::CELL_W-1:0]      rsp_new_row,
   output logic [gnfe_pkg::CELL_W-1:0]      rsp_new_col,
   output logic [gnfe_pkg::COUNT_W-1:0]     rsp_list_total,
   output logic                             rsp_is_end,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [gnfe_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [gnfe_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [gnfe_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready
);
   import gnfe_pkg::*;

`include "grid_neighbour_frontier_expander_unit_defines.svh"

   localparam int RW = $clog2(ROWS);
   localparam int CW = $clog2(COLS);
   localparam logic [RW-1:0]      SWEEP_LAST = RW'(ROWS - 1);
   localparam logic [COORD_W-1:0] ROWS_C     = COORD_W'(ROWS);
   localparam logic [COORD_W-1:0] COLS_C     = COORD_W'(COLS);

   cfg_type cfg;

   state_type state_ff, state_in;

   logic [RING_IDX_W-1:0] idx_ff, idx_in, last_idx_ff, last_idx_in;
   logic [CELL_W-1:0]     row_ff, row_in, col_ff, col_in;
   logic                  last_ff, last_in;
   logic [COORD_W-1:0]    nr_ff, nr_in, nc_ff, nc_in;
   logic [COUNT_W-1:0]    count_ff, count_in;
   logic [RW-1:0]         sweep_ff, sweep_in;
   logic [ROWS-1:0]       row_valid_ff, row_valid_in, mark_valid_ff, mark_valid_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [CELL_W-1:0]     rsp_new_row_ff, rsp_new_row_in, rsp_new_col_ff, rsp_new_col_in;
   logic [COUNT_W-1:0]    rsp_list_total_ff, rsp_list_total_in;
   logic                  rsp_is_end_ff, rsp_is_end_in;

   logic [2*COLS-1:0]     map_mem [ROWS];
   logic [2*COLS-1:0]     rd_data_ff;
   logic                  mem_we;
   logic [RW-1:0]         mem_waddr, mem_raddr;
   logic [2*COLS-1:0]     mem_wdata;

   offset_type            off;
   logic [COORD_W-1:0]    nr_sum, nc_sum, nr_sum_m1, nr_ff_m1, nc_ff_m1;
   logic                  on_board, ring_done, seen, ring2;
   logic [RW-1:0]         nr_idx, eff_idx;
   logic [CW-1:0]         nc_idx;
   logic [COLS-1:0]       hit_bit, eff_vis, eff_mark;
   logic                  req_xfer, rsp_xfer;

   gnfe_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign req_xfer  = req_valid & req_ready;
   assign rsp_xfer  = rsp_valid_ff & rsp_ready;
   assign ring2     = (cfg.ring_level == RING_LEVEL_TWO);

   // shared coordinate adder
   assign off    = ring_offset(idx_ff);
   assign nr_sum = {{(COORD_W-CELL_W){1'b0}}, row_ff}
                 + {{(COORD_W-OFF_W){off.dr[OFF_W-1]}}, off.dr};
   assign nc_sum = {{(COORD_W-CELL_W){1'b0}}, col_ff}
                 + {{(COORD_W-OFF_W){off.dc[OFF_W-1]}}, off.dc};
   assign on_board = !nr_sum[COORD_W-1] && (nr_sum != '0) && (nr_sum <= ROWS_C)
                  && !nc_sum[COORD_W-1] && (nc_sum != '0) && (nc_sum <= COLS_C);
   assign nr_sum_m1 = nr_sum - COORD_W'(1);
   assign nr_ff_m1  = nr_ff - COORD_W'(1);
   assign nc_ff_m1  = nc_ff - COORD_W'(1);
   assign nr_idx    = nr_ff_m1[RW-1:0];
   assign nc_idx    = nc_ff_m1[CW-1:0];
   assign ring_done = (idx_ff == last_idx_ff);

   assign eff_idx  = (state_ff == ST_SWEEP_WR) ? sweep_ff : nr_idx;
   assign eff_vis  = row_valid_ff[eff_idx] ? rd_data_ff[COLS-1:0] : '0;
   assign eff_mark = (row_valid_ff[eff_idx] && mark_valid_ff[eff_idx])
                   ? rd_data_ff[2*COLS-1:COLS] : '0;
   assign hit_bit  = {{(COLS-1){1'b0}}, 1'b1} << nc_idx;
   assign seen     = |(eff_vis & hit_bit);

   assign mem_raddr = (state_ff == ST_SWEEP_RD) ? sweep_ff : nr_sum_m1[RW-1:0];

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) state_in = req_mode ? ST_END : ST_CALC;
         end
         ST_CALC: begin
            if (on_board)       state_in = ST_TEST;
            else if (ring_done) state_in = ST_END;
         end
         ST_TEST: begin
            if (!seen)          state_in = ST_EMIT;
            else if (ring_done) state_in = ST_END;
            else                state_in = ST_CALC;
         end
         ST_EMIT: begin
            if (rsp_xfer) state_in = ring_done ? ST_END : ST_CALC;
         end
         ST_END: state_in = ST_END_WAIT;
         ST_END_WAIT: begin
            if (rsp_xfer) begin
               if (last_ff && !cfg.keep_marks) state_in = ST_SWEEP_RD;
               else                            state_in = ST_IDLE;
            end
         end
         ST_SWEEP_RD: state_in = ST_SWEEP_WR;
         ST_SWEEP_WR: state_in = (sweep_ff == SWEEP_LAST) ? ST_IDLE : ST_SWEEP_RD;
         default:     state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      idx_in            = idx_ff;
      last_idx_in       = last_idx_ff;
      row_in            = row_ff;
      col_in            = col_ff;
      last_in           = last_ff;
      nr_in             = nr_ff;
      nc_in             = nc_ff;
      count_in          = count_ff;
      sweep_in          = sweep_ff;
      row_valid_in      = row_valid_ff;
      mark_valid_in     = mark_valid_ff;
      rsp_valid_in      = rsp_xfer ? 1'b0 : rsp_valid_ff;
      rsp_new_row_in    = rsp_new_row_ff;
      rsp_new_col_in    = rsp_new_col_ff;
      rsp_list_total_in = rsp_list_total_ff;
      rsp_is_end_in     = rsp_is_end_ff;
      mem_we            = 1'b0;
      mem_waddr         = nr_idx;
      mem_wdata         = {eff_mark | hit_bit, eff_vis | hit_bit};
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               row_in      = req_cell_row;
               col_in      = req_cell_col;
               last_in     = req_last_cell & ~req_mode;
               idx_in      = ring2 ? RING2_FIRST : RING1_FIRST;
               last_idx_in = ring2 ? RING2_LAST : RING1_LAST;
               if (req_mode) begin
                  row_valid_in  = '0;
                  mark_valid_in = '0;
                  count_in      = '0;
               end
            end
         end
         ST_CALC: begin
            nr_in = nr_sum;
            nc_in = nc_sum;
            if (!on_board) idx_in = idx_ff + RING_IDX_W'(1);
         end
         ST_TEST: begin
            if (seen) begin
               idx_in = idx_ff + RING_IDX_W'(1);
            end else begin
               mem_we                = 1'b1;
               row_valid_in[nr_idx]  = 1'b1;
               mark_valid_in[nr_idx] = 1'b1;
               if (count_ff != COUNT_MAX) count_in = count_ff + COUNT_W'(1);
               rsp_valid_in      = 1'b1;
               rsp_new_row_in    = nr_ff[CELL_W-1:0];
               rsp_new_col_in    = nc_ff[CELL_W-1:0];
               rsp_list_total_in = '0;
               rsp_is_end_in     = 1'b0;
            end
         end
         ST_EMIT: begin
            if (rsp_xfer) idx_in = idx_ff + RING_IDX_W'(1);
         end
         ST_END: begin
            rsp_valid_in      = 1'b1;
            rsp_new_row_in    = '0;
            rsp_new_col_in    = '0;
            rsp_list_total_in = count_ff;
            rsp_is_end_in     = 1'b1;
         end
         ST_END_WAIT: begin
            if (rsp_xfer && last_ff) begin
               if (cfg.keep_marks) begin
                  mark_valid_in = '0;
                  count_in      = '0;
               end else begin
                  sweep_in = '0;
               end
            end
         end
         ST_SWEEP_RD: ;
         ST_SWEEP_WR: begin
            mem_we    = 1'b1;
            mem_waddr = sweep_ff;
            mem_wdata = {{COLS{1'b0}}, eff_vis & ~eff_mark};
            sweep_in  = sweep_ff + RW'(1);
            if (sweep_ff == SWEEP_LAST) begin
               mark_valid_in = '0;
               count_in      = '0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) map_mem[mem_waddr] <= mem_wdata;
      rd_data_ff <= map_mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         row_valid_ff  <= '0;
         mark_valid_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         row_valid_ff  <= row_valid_in;
         mark_valid_ff <= mark_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff            <= idx_in;
      last_idx_ff       <= last_idx_in;
      row_ff            <= row_in;
      col_ff            <= col_in;
      last_ff           <= last_in;
      nr_ff             <= nr_in;
      nc_ff             <= nc_in;
      sweep_ff          <= sweep_in;
      rsp_new_row_ff    <= rsp_new_row_in;
      rsp_new_col_ff    <= rsp_new_col_in;
      rsp_list_total_ff <= rsp_list_total_in;
      rsp_is_end_ff     <= rsp_is_end_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_new_row    = rsp_new_row_ff;
   assign rsp_new_col    = rsp_new_col_ff;
   assign rsp_list_total = rsp_list_total_ff;
   assign rsp_is_end     = rsp_is_end_ff;

   `GNFE_ASSERT_NOW(a_end_no_coords, rsp_valid_ff && rsp_is_end_ff, rsp_new_row_ff == '0 && rsp_new_col_ff == '0, "end transfer carries coordinates")
   `GNFE_ASSERT_NOW(a_hit_total_zero, rsp_valid_ff && !rsp_is_end_ff, rsp_list_total_ff == '0, "neighbour transfer carries a total")
   `GNFE_ASSERT_NOW(a_test_output_free, state_ff == ST_TEST, !rsp_valid_ff, "output register busy during neighbour check")
   `GNFE_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready, "input taken again while busy")
   `GNFE_ASSERT_NEXT(a_sweep_clears_marks, state_ff == ST_SWEEP_WR && sweep_ff == SWEEP_LAST, mark_valid_ff == '0 && count_ff == '0, "list marks survive revert sweep")

endmodule
